FILE: design/s5cr_pkg.sv
// Shared types, codes and constants for the SOCKS5 connect request parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s5cr_pkg;

    // Wire codes of the ATYP byte
    localparam logic [7:0] ATYP_IPV4   = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN = 8'd3;
    localparam logic [7:0] ATYP_IPV6   = 8'd4;

    // Frame layout
    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam logic [8:0] POS_TYPE       = 9'd3;
    localparam logic [8:0] POS_NAME_LEN   = 9'd4;
    localparam logic [9:0] ADDR_START     = 10'd4;
    localparam logic [9:0] NAME_START     = 10'd5;
    localparam logic [9:0] IPV4_ADDR_LEN  = 10'd4;
    localparam logic [9:0] IPV6_ADDR_LEN  = 10'd16;
    localparam logic [9:0] MIN_LEN        = 10'd4;
    localparam logic [9:0] MIN_DOMAIN_LEN = 10'd5;
    localparam logic [9:0] IPV4_FRAME_LEN = 10'd10;
    localparam logic [9:0] IPV6_FRAME_LEN = 10'd22;
    localparam logic [9:0] DOMAIN_FIXED   = 10'd7;   // header, length byte, port

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ADDR_UNKNOWN = 2'd0,
        ADDR_IPV4    = 2'd1,
        ADDR_DOMAIN  = 2'd2,
        ADDR_IPV6    = 2'd3
    } t_addr_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_LEN_MISMATCH = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ADDR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  address_byte;
        logic [7:0]  address_index;
        logic [1:0]  address_type;
        logic [15:0] dest_port;
        logic [1:0]  frame_status;
        logic        last_of_run;
    } t_res;

    function automatic t_addr_type map_type(input logic [7:0] code);
        t_addr_type at;
        case (code)
            ATYP_IPV4:   at = ADDR_IPV4;
            ATYP_DOMAIN: at = ADDR_DOMAIN;
            ATYP_IPV6:   at = ADDR_IPV6;
            default:     at = ADDR_UNKNOWN;
        endcase
        return at;
    endfunction

endpackage

`default_nettype wire

FILE: design/socks5_connect_request_parser.sv
// Top level of the SOCKS5 connect request parser: byte tracking and result queue.
// Depends on s5cr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Parses a SOCKS5 connect request (VER, CMD, RSV, ATYP, address, port) that
// arrives one byte per transaction, frame_end flagging the last byte. Every
// destination address byte comes out as an address result with its index in
// the address; the last byte of the frame also yields a summary with the
// address type, the big-endian port and a status (ok, too short, unknown type,
// length mismatch). When the last byte is itself an address byte, the address
// result comes first. While o_ready is high the block takes one byte per cycle:
// the byte is decoded in the cycle it is accepted and its zero, one or two
// results are written into a four-entry result queue, which drains one result
// per cycle while i_ready is high. Input ready is held low only while the
// queue has fewer than two free entries, so a frame streams at one byte per
// cycle while output keeps up; a frame-ending address byte gives two results.
// Version and command bytes are not checked. The byte counter saturates at 511.
module socks5_connect_request_parser (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire s5cr_pkg::t_req i_req,
    output logic             o_valid,
    input  wire              i_ready,
    output s5cr_pkg::t_res   o_res
);
    import s5cr_pkg::*;

    // Frame state
    logic [8:0] r_pos, n_pos;
    logic [7:0] r_type, n_type;
    logic [7:0] r_nlen, n_nlen;
    logic [7:0] r_port_hi, n_port_hi;
    logic [7:0] r_port_lo, n_port_lo;

    // Result queue
    t_res              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic       in_acc, out_acc;
    logic [7:0] tc_eff, nl_eff, ph_eff, pl_eff;
    logic [9:0] pos10, addr_start, addr_len, port_at, frame_len, expect_len;
    logic       has_addr, in_addr_range;
    t_addr_type sum_type;
    t_status    sum_status;
    t_res       addr_res, sum_res;
    logic [QCNT_W-1:0] n_writes;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Two free slots guarantee room for the worst case of two results.
    assign o_ready = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rptr];

    // Byte decode
    always_comb begin
        pos10  = {1'b0, r_pos};
        tc_eff = (r_pos == POS_TYPE) ? i_req.data_byte : r_type;
        nl_eff = (r_pos == POS_NAME_LEN && tc_eff == ATYP_DOMAIN) ? i_req.data_byte : r_nlen;

        addr_start = ADDR_START;
        addr_len   = '0;
        if (pos10 >= ADDR_START) begin
            case (tc_eff)
                ATYP_IPV4:   addr_len = IPV4_ADDR_LEN;
                ATYP_IPV6:   addr_len = IPV6_ADDR_LEN;
                ATYP_DOMAIN: begin
                    addr_start = NAME_START;
                    addr_len   = {2'b00, nl_eff};
                end
                default:     addr_len = '0;
            endcase
        end
        port_at = addr_start + addr_len;

        ph_eff        = r_port_hi;
        pl_eff        = r_port_lo;
        in_addr_range = 1'b0;
        if (addr_len != '0 || (tc_eff == ATYP_DOMAIN && pos10 >= NAME_START)) begin
            if (pos10 >= addr_start && pos10 < port_at) begin
                in_addr_range = 1'b1;
            end else if (pos10 == port_at) begin
                ph_eff = i_req.data_byte;
            end else if (pos10 == port_at + 10'd1) begin
                pl_eff = i_req.data_byte;
            end
        end
        has_addr = in_addr_range;

        // Frame summary
        frame_len  = pos10 + 10'd1;
        sum_type   = (frame_len >= MIN_LEN) ? map_type(tc_eff) : ADDR_UNKNOWN;
        expect_len = DOMAIN_FIXED + {2'b00, nl_eff};
        case (sum_type)
            ADDR_IPV4:   expect_len = IPV4_FRAME_LEN;
            ADDR_IPV6:   expect_len = IPV6_FRAME_LEN;
            default:     expect_len = DOMAIN_FIXED + {2'b00, nl_eff};
        endcase
        if (frame_len < MIN_LEN) begin
            sum_status = ST_SHORT;
        end else if (sum_type == ADDR_UNKNOWN) begin
            sum_status = ST_BAD_TYPE;
        end else if (sum_type == ADDR_DOMAIN && frame_len < MIN_DOMAIN_LEN) begin
            sum_status = ST_SHORT;
        end else if (frame_len == expect_len) begin
            sum_status = ST_OK;
        end else begin
            sum_status = ST_LEN_MISMATCH;
        end

        addr_res.result_kind   = KIND_ADDR;
        addr_res.address_byte  = i_req.data_byte;
        addr_res.address_index = 8'(pos10 - addr_start);
        addr_res.address_type  = map_type(tc_eff);
        addr_res.dest_port     = '0;
        addr_res.frame_status  = ST_OK;
        addr_res.last_of_run   = !i_req.frame_end;

        sum_res.result_kind   = KIND_SUMMARY;
        sum_res.address_byte  = '0;
        sum_res.address_index = '0;
        sum_res.address_type  = sum_type;
        sum_res.dest_port     = (sum_status == ST_OK) ? {ph_eff, pl_eff} : 16'd0;
        sum_res.frame_status  = sum_status;
        sum_res.last_of_run   = 1'b1;

        n_writes = QCNT_W'(has_addr) + QCNT_W'(i_req.frame_end);
    end

    // Next frame state
    always_comb begin
        n_pos     = r_pos;
        n_type    = r_type;
        n_nlen    = r_nlen;
        n_port_hi = r_port_hi;
        n_port_lo = r_port_lo;
        if (in_acc) begin
            if (i_req.frame_end) begin
                n_pos     = '0;
                n_type    = '0;
                n_nlen    = '0;
                n_port_hi = '0;
                n_port_lo = '0;
            end else begin
                n_pos     = (r_pos < POS_MAX) ? r_pos + 9'd1 : r_pos;
                n_type    = tc_eff;
                n_nlen    = nl_eff;
                n_port_hi = ph_eff;
                n_port_lo = pl_eff;
            end
        end
        n_cnt = r_cnt + (in_acc ? n_writes : '0) - QCNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_type    <= '0;
            r_nlen    <= '0;
            r_port_hi <= '0;
            r_port_lo <= '0;
            r_cnt     <= '0;
            r_wptr    <= '0;
            r_rptr    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_nlen    <= n_nlen;
            r_port_hi <= n_port_hi;
            r_port_lo <= n_port_lo;
            r_cnt     <= n_cnt;
            if (in_acc) begin
                r_wptr <= r_wptr + QPTR_W'(n_writes);
            end
            if (out_acc) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (has_addr) begin
                r_q[r_wptr] <= addr_res;
            end
            if (i_req.frame_end) begin
                r_q[has_addr ? r_wptr + QPTR_W'(1) : r_wptr] <= sum_res;
            end
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.frame_end) |=> (r_pos == '0 && r_type == '0))
        else $error("frame state not cleared after frame end");

    a_pos_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_MAX && !(in_acc && i_req.frame_end)) |=> (r_pos == POS_MAX))
        else $error("byte position left saturation");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_cnt > QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("input stalled with queue room");

endmodule

`default_nettype wire
